>>> src/gg_pkg.sv
// ----------------------------------------------------------------------------
// gg_pkg: shared definitions for the generation step core
// Command codes carried in the input side-band and their type.
// ----------------------------------------------------------------------------
package gg_pkg;

  // Command carried with each input word.
  typedef logic [1:0] act_t;

  localparam act_t ACT_LOAD = 2'd0;
  localparam act_t ACT_GEN  = 2'd1;
  localparam act_t ACT_READ = 2'd2;
  localparam act_t ACT_NOP  = 2'd3;

endpackage

>>> src/gg_ram.sv
// ----------------------------------------------------------------------------
// gg_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; read data holds while the
// read enable is low.
// ----------------------------------------------------------------------------
module gg_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 6,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/genetic_generation_step_core.sv
// ----------------------------------------------------------------------------
// genetic_generation_step_core: steady-state genetic algorithm step
// Holds a population of binary chromosomes in a small RAM, loads and reads
// slots, and runs one selection, crossover, mutation and replacement step.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready with the command in s_tuser
//   (load, generation, read, no-op). Every accepted word yields exactly
//   one result word on m_tvalid/m_tready.
//   Load and read pass through the accept cycle, in which the RAM is
//   written or read, and a final cycle that forms the result.
//   A generation makes one RAM read per slot while the fittest and
//   least-fit trackers update, then writes both children in turn through
//   the single RAM write port, and last forms the result. The single RAM
//   read port sets the scan length.
//   The block takes one word at a time; s_tready is high only between
//   words. A finished result sits in the output register while the next
//   word is accepted and processed; a stalled receiver holds the block in
//   its final cycle until the output register frees up.
//   Reset clears the control state and the output valid. The population is
//   not cleared; every slot must be loaded before a read or a generation.
// ----------------------------------------------------------------------------
module genetic_generation_step_core #(
  parameter int POPULATION = 6,
  parameter int GENE_COUNT = 5,
  localparam int SW    = $clog2(POPULATION),
  localparam int CW    = $clog2(GENE_COUNT + 1),
  localparam int IN_W  = SW + GENE_COUNT + CW + 2 * GENE_COUNT,
  localparam int OUT_W = 5 * GENE_COUNT + 4 * SW,
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // slot_index, chromosome_in, cross_point, flip_mask_one, flip_mask_two
  input  logic [IN_TW-1:0]  s_tdata,
  // action
  input  gg_pkg::act_t      s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // read_value, read_score, first_parent, second_parent, child_one,
  // child_two, replaced_one, replaced_two
  output logic [OUT_TW-1:0] m_tdata
);

  import gg_pkg::*;

  localparam int G = GENE_COUNT;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WR1  = 3'd2;
  localparam logic [2:0] S_WR2  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [SW:0]   POP_LIM = (SW + 1)'(POPULATION);
  localparam logic [SW-1:0] LAST    = SW'(POPULATION - 1);

  // Input word fields.
  logic [SW-1:0] in_slot;
  logic [G-1:0]  in_chrom;
  logic [CW-1:0] in_cross;
  logic [G-1:0]  in_mask1;
  logic [G-1:0]  in_mask2;
  logic          in_ok;
  logic          accept;

  assign in_slot  = s_tdata[SW-1:0];
  assign in_chrom = s_tdata[SW +: G];
  assign in_cross = s_tdata[SW + G +: CW];
  assign in_mask1 = s_tdata[SW + G + CW +: G];
  assign in_mask2 = s_tdata[SW + 2 * G + CW +: G];
  assign in_ok    = {1'b0, in_slot} < POP_LIM;

  // Control and held item registers.
  logic [2:0]    state, state_next;
  logic [SW-1:0] cnt;
  act_t          act;
  logic          slot_ok;
  logic [CW-1:0] cross_pt;
  logic [G-1:0]  mask1, mask2;

  // Selection trackers.
  logic [SW-1:0] best, second, worst, sworst;
  logic [G-1:0]  best_val, second_val, worst_val, sworst_val;
  logic          have_best, have_second, have_worst, have_sworst;
  logic [SW-1:0] best_next, second_next, worst_next, sworst_next;
  logic [G-1:0]  best_val_next, second_val_next, worst_val_next, sworst_val_next;
  logic          have_best_next, have_second_next, have_worst_next, have_sworst_next;

  // RAM ports.
  logic          ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  logic [G-1:0]  ram_wdata, rdata;

  // Children, read score and the result word being formed.
  logic [G-1:0]      head, child1, child2;
  logic [2*G-1:0]    score;
  logic [OUT_TW-1:0] res_word;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  gg_ram #(
    .WIDTH(G),
    .DEPTH(POPULATION)
  ) u_pop (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  // RAM write: load on accept, then the two children after a scan.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_slot;
    ram_wdata = in_chrom;
    if (state == S_IDLE) begin
      ram_we = accept && (s_tuser == ACT_LOAD) && in_ok;
    end else if (state == S_WR1) begin
      ram_we    = 1'b1;
      ram_waddr = worst;
      ram_wdata = child1;
    end else if (state == S_WR2) begin
      ram_we    = 1'b1;
      ram_waddr = sworst;
      ram_wdata = child2;
    end
  end

  // RAM read: a read word on accept, or slot by slot through the scan.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = in_slot;
    if (state == S_IDLE) begin
      if (s_tuser == ACT_GEN) begin
        ram_raddr = '0;
        ram_re    = accept;
      end else begin
        ram_re = accept && (s_tuser == ACT_READ) && in_ok;
      end
    end else if (state == S_SCAN) begin
      ram_raddr = cnt + 1'b1;
      ram_re    = (cnt != LAST);
    end
  end

  // Tracker update for the slot whose chromosome is on the read port.
  // The fitness is monotonic in the chromosome, so the raw values compare.
  always_comb begin
    best_next        = best;
    best_val_next    = best_val;
    have_best_next   = have_best;
    second_next      = second;
    second_val_next  = second_val;
    have_second_next = have_second;
    worst_next       = worst;
    worst_val_next   = worst_val;
    have_worst_next  = have_worst;
    sworst_next      = sworst;
    sworst_val_next  = sworst_val;
    have_sworst_next = have_sworst;
    priority if (!have_best || rdata > best_val) begin
      second_next      = best;
      second_val_next  = best_val;
      have_second_next = have_best;
      best_next        = cnt;
      best_val_next    = rdata;
      have_best_next   = 1'b1;
    end else if (!have_second || rdata > second_val) begin
      second_next      = cnt;
      second_val_next  = rdata;
      have_second_next = 1'b1;
    end else begin
      // Both fittest entries stand.
      second_next = second;
    end
    priority if (!have_worst || rdata < worst_val) begin
      sworst_next      = worst;
      sworst_val_next  = worst_val;
      have_sworst_next = have_worst;
      worst_next       = cnt;
      worst_val_next   = rdata;
      have_worst_next  = 1'b1;
    end else if (!have_sworst || rdata < sworst_val) begin
      sworst_next      = cnt;
      sworst_val_next  = rdata;
      have_sworst_next = 1'b1;
    end else begin
      // Both least-fit entries stand.
      sworst_next = sworst;
    end
  end

  // Crossover, mutation: child1/child2 take top cross_pt genes from parent 1/2.
  always_comb begin
    for (int g = 0; g < G; g++) begin
      head[G-1-g] = (g < int'(cross_pt));
    end
    child1 = ((best_val & head) | (second_val & ~head)) ^ mask1;
    child2 = ((second_val & head) | (best_val & ~head)) ^ mask2;
  end

  assign score = {{G{1'b0}}, rdata} * {{G{1'b0}}, rdata};

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (s_tuser == ACT_GEN) ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (cnt == LAST) begin
          state_next = S_WR1;
        end
      end
      S_WR1: state_next = S_WR2;
      S_WR2: state_next = S_FIN;
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      have_best   <= 1'b0;
      have_second <= 1'b0;
      have_worst  <= 1'b0;
      have_sworst <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt         <= '0;
        have_best   <= 1'b0;
        have_second <= 1'b0;
        have_worst  <= 1'b0;
        have_sworst <= 1'b0;
      end else if (state == S_SCAN) begin
        cnt         <= cnt + 1'b1;
        have_best   <= have_best_next;
        have_second <= have_second_next;
        have_worst  <= have_worst_next;
        have_sworst <= have_sworst_next;
      end
    end
  end

  // Held fields of the current word and tracker payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= s_tuser;
      slot_ok  <= in_ok;
      cross_pt <= in_cross;
      mask1    <= in_mask1;
      mask2    <= in_mask2;
    end
    if (state == S_SCAN) begin
      best       <= best_next;
      best_val   <= best_val_next;
      second     <= second_next;
      second_val <= second_val_next;
      worst      <= worst_next;
      worst_val  <= worst_val_next;
      sworst     <= sworst_next;
      sworst_val <= sworst_val_next;
    end
  end

  // Result word: read fields, generation fields, or all zero.
  always_comb begin
    res_word = '0;
    if (act == ACT_READ && slot_ok) begin
      res_word[G-1:0]    = rdata;
      res_word[G +: 2*G] = score;
    end else if (act == ACT_GEN) begin
      res_word[3*G +: SW]        = best;
      res_word[3*G + SW +: SW]   = second;
      res_word[3*G + 2*SW +: G]  = child1;
      res_word[4*G + 2*SW +: G]  = child2;
      res_word[5*G + 2*SW +: SW] = worst;
      res_word[5*G + 3*SW +: SW] = sworst;
    end
  end

  // Output register: loaded in the final cycle once the previous word left.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_FIN && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!m_tvalid || m_tready)) begin
      m_tdata <= res_word;
    end
  end

endmodule

>>> src/gg_checker.sv
// ----------------------------------------------------------------------------
// gg_checker: port-level checks for the generation step core
// Watches the stream ports and flags handshake and result inconsistencies.
// ----------------------------------------------------------------------------
module gg_checker #(
  parameter int POPULATION = 6,
  parameter int GENE_COUNT = 5,
  localparam int SW    = $clog2(POPULATION),
  localparam int OUT_W = 5 * GENE_COUNT + 4 * SW,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input gg_pkg::act_t      s_tuser,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_TW-1:0] m_tdata
);

  import gg_pkg::*;

  localparam int G = GENE_COUNT;

  logic [G-1:0]   rv;
  logic [2*G-1:0] rs;
  logic [SW-1:0]  fp, sp, r1, r2;
  logic           gen_word;

  assign rv = m_tdata[G-1:0];
  assign rs = m_tdata[G +: 2*G];
  assign fp = m_tdata[3*G +: SW];
  assign sp = m_tdata[3*G + SW +: SW];
  assign r1 = m_tdata[5*G + 2*SW +: SW];
  assign r2 = m_tdata[5*G + 3*SW +: SW];
  assign gen_word = s_tvalid && s_tready && (s_tuser == ACT_GEN);

  // No result word right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // The reported score is always the square of the reported value.
  a_score: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> rs == {{G{1'b0}}, rv} * {{G{1'b0}}, rv})
    else $error("read score does not match read value");

  // Parents and replaced slots are distinct, or all zero on other words.
  a_distinct: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (fp != sp && r1 != r2) ||
                 (fp == '0 && sp == '0 && r1 == '0 && r2 == '0))
    else $error("generation reported a repeated slot");

  // A generation is accepted and then holds s_tready low as its scan begins.
  a_gen_latency: assert property (@(posedge clk) disable iff (rst)
    gen_word |=> !s_tready ##1 !s_tready)
    else $error("generation finished too early");

endmodule

bind genetic_generation_step_core gg_checker #(
  .POPULATION(POPULATION),
  .GENE_COUNT(GENE_COUNT)
) u_gg_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the genetic generation step core
// Streams load, read, generation and no-op words into the core and checks
// each result word against a model of the population kept in a scoreboard.
// A directed opening covers ties, out-of-range slots, and wide and narrow
// crossover points. Random bursts follow while the receiver stalls, with
// one long hold-off that backs the core up.
// ----------------------------------------------------------------------------
module tb_top;
  import gg_pkg::*;

  localparam int SLOT_COUNT       = 6;
  localparam int IN_TW            = 24;
  localparam int OUT_TW           = 40;
  localparam int MAX_REPORTS      = 10;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 40;

  // One command word as the sender sees it.
  typedef struct packed {
    act_t       action;
    logic [2:0] slot;
    logic [4:0] chrom;
    logic [2:0] point;
    logic [4:0] mask_one;
    logic [4:0] mask_two;
  } gen_cmd_t;

  // One result word split into its fields.
  typedef struct packed {
    logic [4:0] read_value;
    logic [9:0] read_score;
    logic [2:0] first_parent;
    logic [2:0] second_parent;
    logic [4:0] child_one;
    logic [4:0] child_two;
    logic [2:0] replaced_one;
    logic [2:0] replaced_two;
  } gen_result_t;

  // Keeps its own copy of the population and the results still owed.
  class gen_step_scoreboard;
    logic [4:0]  population [SLOT_COUNT];
    gen_result_t expected_results [$];
    int          mismatches;

    function new();
      mismatches = 0;
      foreach (population[i]) population[i] = '0;
    endfunction

    function logic [9:0] fitness(logic [4:0] chrom);
      return 10'(chrom) * 10'(chrom);
    endfunction

    // Applies one command to the population and returns the result it owes.
    function gen_result_t advance_population(gen_cmd_t cmd);
      gen_result_t r;
      int          best, second, worst, second_worst;
      bit          have_best, have_second, have_worst, have_second_worst;
      logic [9:0]  f, best_fit, second_fit, worst_fit, second_worst_fit;
      logic [4:0]  head, p1, p2, c1, c2;
      r = '0;
      best = 0; second = 0; worst = 0; second_worst = 0;
      have_best = 0; have_second = 0; have_worst = 0; have_second_worst = 0;
      best_fit = '0; second_fit = '0; worst_fit = '0; second_worst_fit = '0;
      case (cmd.action)
        ACT_LOAD: begin
          if (cmd.slot < SLOT_COUNT) population[cmd.slot] = cmd.chrom;
        end
        ACT_READ: begin
          if (cmd.slot < SLOT_COUNT) begin
            r.read_value = population[cmd.slot];
            r.read_score = fitness(population[cmd.slot]);
          end
        end
        ACT_GEN: begin
          // Track the two fittest and two least-fit slots; earlier slots win ties.
          for (int i = 0; i < SLOT_COUNT; i++) begin
            f = fitness(population[i]);
            if (!have_best || f > best_fit) begin
              second = best; second_fit = best_fit; have_second = have_best;
              best = i; best_fit = f; have_best = 1;
            end else if (!have_second || f > second_fit) begin
              second = i; second_fit = f; have_second = 1;
            end
            if (!have_worst || f < worst_fit) begin
              second_worst = worst; second_worst_fit = worst_fit;
              have_second_worst = have_worst;
              worst = i; worst_fit = f; have_worst = 1;
            end else if (!have_second_worst || f < second_worst_fit) begin
              second_worst = i; second_worst_fit = f; have_second_worst = 1;
            end
          end
          // Genes below the crossover point sit in the upper bits.
          head = '0;
          for (int g = 0; g < 5; g++) begin
            if (g < cmd.point) head[4 - g] = 1'b1;
          end
          p1 = population[best];
          p2 = population[second];
          c1 = ((p1 & head) | (p2 & ~head)) ^ cmd.mask_one;
          c2 = ((p2 & head) | (p1 & ~head)) ^ cmd.mask_two;
          population[worst] = c1;
          population[second_worst] = c2;
          r.first_parent  = 3'(best);
          r.second_parent = 3'(second);
          r.child_one     = c1;
          r.child_two     = c2;
          r.replaced_one  = 3'(worst);
          r.replaced_two  = 3'(second_worst);
        end
        default: begin
        end
      endcase
      return r;
    endfunction

    function void note_word(gen_cmd_t cmd);
      expected_results.push_back(advance_population(cmd));
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Mismatch in %s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_word(logic [OUT_TW-1:0] data);
      gen_result_t got, want;
      got.read_value    = data[4:0];
      got.read_score    = data[14:5];
      got.first_parent  = data[17:15];
      got.second_parent = data[20:18];
      got.child_one     = data[25:21];
      got.child_two     = data[30:26];
      got.replaced_one  = data[33:31];
      got.replaced_two  = data[36:34];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result word %h with nothing pending", data);
        return;
      end
      want = expected_results.pop_front();
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("read_score", want.read_score, got.read_score);
      compare_field("first_parent", want.first_parent, got.first_parent);
      compare_field("second_parent", want.second_parent, got.second_parent);
      compare_field("child_one", want.child_one, got.child_one);
      compare_field("child_two", want.child_two, got.child_two);
      compare_field("replaced_one", want.replaced_one, got.replaced_one);
      compare_field("replaced_two", want.replaced_two, got.replaced_two);
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  // slot_index, chromosome_in, cross_point, flip_mask_one, flip_mask_two
  logic [IN_TW-1:0]  s_tdata;
  // action
  act_t              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  // read_value, read_score, first_parent, second_parent, child_one,
  // child_two, replaced_one, replaced_two
  logic [OUT_TW-1:0] m_tdata;

  gen_step_scoreboard scoreboard = new();
  bit                 long_hold = 1'b0;
  int                 cycle_count = 0;

  genetic_generation_step_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Check every result word accepted by the receiver.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) scoreboard.check_word(m_tdata);
  end

  // Receiver: stretches of different stall rates, plus one long hold-off on request.
  initial begin : receiver
    int stall_pct;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          default: stall_pct = 75;
        endcase
        for (int k = 0; k < 40; k++) begin
          m_tready <= ($urandom_range(0, 99) >= stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  // Offers one word and waits until it is taken; valid stays high afterward.
  task automatic offer_word(gen_cmd_t cmd);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd.action;
    s_tdata  <= {3'b000, cmd.mask_two, cmd.mask_one, cmd.point, cmd.chrom, cmd.slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    scoreboard.note_word(cmd);
  endtask

  // Idle gap with junk on the data lines.
  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= IN_TW'($urandom);
      s_tuser  <= act_t'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (scoreboard.outstanding() != 0) @(posedge clk);
  endtask

  function automatic gen_cmd_t make_command(act_t action, int slot, int chrom, int point,
                                            int mask_one, int mask_two);
    gen_cmd_t cmd;
    cmd.action   = action;
    cmd.slot     = 3'(slot);
    cmd.chrom    = 5'(chrom);
    cmd.point    = 3'(point);
    cmd.mask_one = 5'(mask_one);
    cmd.mask_two = 5'(mask_two);
    return cmd;
  endfunction

  // Generations lead, slots mostly valid; masks often zero so the population converges.
  function automatic gen_cmd_t random_command();
    gen_cmd_t cmd;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      cmd.action = ACT_LOAD;
    else if (pick < 65) cmd.action = ACT_GEN;
    else if (pick < 93) cmd.action = ACT_READ;
    else                cmd.action = ACT_NOP;
    cmd.slot     = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
    cmd.chrom    = 5'($urandom);
    cmd.point    = 3'($urandom);
    cmd.mask_one = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'b0;
    cmd.mask_two = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'b0;
    return cmd;
  endfunction

  // Random words in bursts of random length separated by random gaps.
  task automatic run_random(int count);
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
      end
      offer_word(random_command());
      burst--;
    end
  endtask

  initial begin : stimulus
    gen_cmd_t directed [$];
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= ACT_NOP;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every slot first, with tied fitness values among them.
    directed.push_back(make_command(ACT_LOAD, 0, 7, 0, 0, 0));
    directed.push_back(make_command(ACT_LOAD, 1, 31, 0, 0, 0));
    directed.push_back(make_command(ACT_LOAD, 2, 0, 0, 0, 0));
    directed.push_back(make_command(ACT_LOAD, 3, 31, 0, 0, 0));
    directed.push_back(make_command(ACT_LOAD, 4, 7, 0, 0, 0));
    directed.push_back(make_command(ACT_LOAD, 5, 16, 0, 0, 0));
    // Loads beyond the population are dropped; reads there return zero.
    directed.push_back(make_command(ACT_LOAD, 6, 31, 0, 0, 0));
    directed.push_back(make_command(ACT_LOAD, 7, 31, 7, 31, 31));
    directed.push_back(make_command(ACT_READ, 1, 0, 0, 0, 0));
    directed.push_back(make_command(ACT_READ, 2, 31, 7, 31, 31));
    directed.push_back(make_command(ACT_READ, 6, 0, 0, 0, 0));
    directed.push_back(make_command(ACT_READ, 7, 0, 0, 0, 0));
    // Unused action with every other field at its top value.
    directed.push_back(make_command(ACT_NOP, 7, 31, 7, 31, 31));
    // Crossover point at zero, at full width, and above the gene count.
    directed.push_back(make_command(ACT_GEN, 0, 0, 0, 0, 0));
    directed.push_back(make_command(ACT_GEN, 0, 0, 7, 31, 31));
    directed.push_back(make_command(ACT_GEN, 0, 0, 5, 21, 10));
    directed.push_back(make_command(ACT_GEN, 0, 0, 2, 0, 0));
    // Whole population tied: parents and replaced slots fall to the earliest ones.
    for (int s = 0; s < SLOT_COUNT; s++)
      directed.push_back(make_command(ACT_LOAD, s, 9, 0, 0, 0));
    directed.push_back(make_command(ACT_GEN, 0, 0, 3, 0, 0));
    directed.push_back(make_command(ACT_READ, 0, 0, 0, 0, 0));

    foreach (directed[i]) begin
      offer_word(directed[i]);
      pause_sender($urandom_range(0, 3));
    end
    wait_for_results();

    run_random(260);

    // Receiver holds off while the sender keeps offering words back to back.
    long_hold = 1'b1;
    for (int n = 0; n < 20; n++) offer_word(random_command());

    // Sender stops until every owed result has come back.
    wait_for_results();

    run_random(300);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/gg_pkg.sv
src/gg_ram.sv
src/genetic_generation_step_core.sv
src/gg_checker.sv
tb/tb_top.sv
